// File: design/c3f_pkg.sv
// Shared types and constants for the 3x3 convolution filter.
// No dependencies; imported by c3f_cell and conv3x3_image_filter_top.
`default_nettype none

package c3f_pkg;

  localparam int PIX_W      = 8;   // pixel sample
  localparam int COEF_W     = 12;  // one Q8.4 coefficient
  localparam int KERNEL_W   = 3 * COEF_W;
  localparam int PROD_W     = 21;  // 9-bit signed pixel times 12-bit coefficient
  localparam int ROW_W      = 23;  // sum of three products
  localparam int OUT_W      = 24;  // filtered value
  localparam int POS_W      = 9;   // center row / column on the output
  localparam int LWIDTH_W   = 10;  // line width register
  localparam int CFG_IDX_W  = 2;
  localparam int TDATA_O_W  = 48;  // 24 + 9 + 9 padded to whole bytes

  localparam int DEF_MAX_WIDTH  = 512;
  localparam int DEF_MAX_HEIGHT = 512;

  // Laplacian: 0 1 0 / 1 -4 1 / 0 1 0 in Q8.4, left coefficient in the low bits
  localparam logic [KERNEL_W-1:0] KERNEL_EDGE_RST = 36'h0_0001_0000;
  localparam logic [KERNEL_W-1:0] KERNEL_MID_RST  = 36'h0_10FC_0010;
  localparam logic [LWIDTH_W-1:0] LWIDTH_RST      = 10'd512;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KERNEL_TOP    = 2'd0,
    CFG_KERNEL_MIDDLE = 2'd1,
    CFG_KERNEL_BOTTOM = 2'd2,
    CFG_LINE_WIDTH    = 2'd3
  } c3f_cfg_e;

  // Pipeline controls handed to every cell
  typedef struct packed {
    logic accept;    // pixel taken this cycle, line stores read
    logic advance;   // stage-1 item moves on: store write, window shift, products
    logic sum_load;  // stage-2 products folded into the row sum
  } c3f_ctrl_t;

endpackage

`default_nettype wire

// File: design/conv3x3_image_filter_top.sv
// 3x3 image convolution: row and column counters, kernel registers, a chain
// of three row cells and the output register. Uses c3f_pkg and c3f_cell.
// Pipeline: a pixel passes the stage-1, product, row-sum and output registers
// before its result is valid; the result waits while the result stream stalls.
// Throughput: one pixel per cycle while the result stream does not stall; line
// stores are single-port-per-side RAMs read at acceptance and written as the
// pixel leaves stage 1, with a same-column bypass.
// Reset: counters and pipeline valids clear, kernel returns to the Laplacian,
// line width to 512; line store contents are left as they are.
`default_nettype none

module conv3x3_image_filter_top #(
  parameter int MAX_WIDTH  = c3f_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = c3f_pkg::DEF_MAX_HEIGHT
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  // configuration
  input  wire                               cfg_we_i,
  input  wire  [c3f_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire  [c3f_pkg::KERNEL_W-1:0]      cfg_wdata_i,
  // pixel stream
  input  wire                               s_axis_tvalid,
  output logic                              s_axis_tready,
  input  wire  [c3f_pkg::PIX_W-1:0]         s_axis_tdata,  // [7:0] pixel
  input  wire                               s_axis_tuser,  // [0] frame_start
  // result stream
  output logic                              m_axis_tvalid,
  input  wire                               m_axis_tready,
  // [23:0] filtered_value, [32:24] center_row, [41:33] center_column, rest 0
  output logic [c3f_pkg::TDATA_O_W-1:0]     m_axis_tdata,
  output logic                              m_axis_tlast   // row_done
);
  import c3f_pkg::*;

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT + 1);
  localparam int LW  = (CW + 1 > LWIDTH_W) ? CW + 1 : LWIDTH_W;
  localparam int CXW = (CW > POS_W) ? CW : POS_W;
  localparam int RXW = (RW > POS_W) ? RW : POS_W;

  // ---------------- configuration ----------------
  logic [KERNEL_W-1:0] ktop_q, kmid_q, kbot_q;
  logic [LWIDTH_W-1:0] lwidth_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ktop_q   <= KERNEL_EDGE_RST;
      kmid_q   <= KERNEL_MID_RST;
      kbot_q   <= KERNEL_EDGE_RST;
      lwidth_q <= LWIDTH_RST;
    end else if (cfg_we_i) begin
      case (c3f_cfg_e'(cfg_idx_i))
        CFG_KERNEL_TOP:    ktop_q   <= cfg_wdata_i;
        CFG_KERNEL_MIDDLE: kmid_q   <= cfg_wdata_i;
        CFG_KERNEL_BOTTOM: kbot_q   <= cfg_wdata_i;
        CFG_LINE_WIDTH:    lwidth_q <= cfg_wdata_i[LWIDTH_W-1:0];
        default: ;
      endcase
    end
  end

  logic [LW-1:0] lw_ext, eff_width;
  assign lw_ext    = LW'(lwidth_q);
  assign eff_width = (lw_ext < LW'(3)) ? LW'(3) :
                     (lw_ext > LW'(MAX_WIDTH)) ? LW'(MAX_WIDTH) : lw_ext;

  // ---------------- pipeline control ----------------
  logic v1_q, v2_q, v3_q, vo_q;
  logic en1, en2, en3, en_o;
  logic accept, advance;

  assign en_o    = !vo_q || m_axis_tready;
  assign en3     = !v3_q || en_o;
  assign en2     = !v2_q || en3;
  assign en1     = !v1_q || en2;
  assign s_axis_tready = en1;
  assign accept  = s_axis_tvalid && en1;
  assign advance = v1_q && en2;

  c3f_ctrl_t ctrl;
  assign ctrl.accept   = accept;
  assign ctrl.advance  = advance;
  assign ctrl.sum_load = v2_q && en3;

  // ---------------- stage 0: position counters ----------------
  logic [CW-1:0] col_q, col_d, cur_col;
  logic [RW-1:0] row_q, row_d, cur_row;
  logic          row_end, has_res;
  logic [CXW-1:0] ccol_ext;
  logic [RXW-1:0] crow_ext;

  assign cur_col  = s_axis_tuser ? '0 : col_q;
  assign cur_row  = s_axis_tuser ? '0 : row_q;
  assign row_end  = (LW'(cur_col) + LW'(1)) >= eff_width;
  assign has_res  = (cur_row >= RW'(2)) && (cur_row < RW'(MAX_HEIGHT)) &&
                    (cur_col >= CW'(2));
  assign ccol_ext = CXW'(cur_col) - CXW'(1);
  assign crow_ext = RXW'(cur_row) - RXW'(1);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (row_end) begin
        col_d = '0;
        row_d = (cur_row < RW'(MAX_HEIGHT)) ? cur_row + RW'(1) : cur_row;
      end else begin
        col_d = cur_col + CW'(1);
        row_d = cur_row;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // ---------------- stage registers ----------------
  logic [PIX_W-1:0] px1_q;
  logic [CW-1:0]    c1_q;
  logic             res1_q, last1_q, last2_q, last3_q, last_o_q;
  logic [POS_W-1:0] crow1_q, ccol1_q, crow2_q, ccol2_q, crow3_q, ccol3_q;
  logic [POS_W-1:0] crow_o_q, ccol_o_q;
  logic [OUT_W-1:0] sum_o_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (en1)  v1_q <= s_axis_tvalid;
      if (en2)  v2_q <= v1_q && res1_q;
      if (en3)  v3_q <= v2_q;
      if (en_o) vo_q <= v3_q;
    end
  end

  logic signed [ROW_W-1:0] rsum0, rsum1, rsum2;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      px1_q   <= s_axis_tdata;
      c1_q    <= cur_col;
      res1_q  <= has_res;
      last1_q <= row_end;
      crow1_q <= crow_ext[POS_W-1:0];
      ccol1_q <= ccol_ext[POS_W-1:0];
    end
    if (advance) begin
      last2_q <= last1_q;
      crow2_q <= crow1_q;
      ccol2_q <= ccol1_q;
    end
    if (ctrl.sum_load) begin
      last3_q <= last2_q;
      crow3_q <= crow2_q;
      ccol3_q <= ccol2_q;
    end
    if (v3_q && en_o) begin
      last_o_q <= last3_q;
      crow_o_q <= crow3_q;
      ccol_o_q <= ccol3_q;
      sum_o_q  <= OUT_W'(rsum0) + OUT_W'(rsum1) + OUT_W'(rsum2);
    end
  end

  // ---------------- cell chain: bottom row feeds upward ----------------
  logic [PIX_W-1:0] pix_mid, pix_top, pix_unused;

  c3f_cell #(.MAX_WIDTH(MAX_WIDTH), .HAS_STORE(1'b1)) u_cell_bot (
    .clk_i, .rst_ni,
    .ctrl_i    (ctrl),
    .rd_addr_i (cur_col),
    .wr_addr_i (c1_q),
    .kernel_i  (kbot_q),
    .pix_i     (px1_q),
    .pix_up_o  (pix_mid),
    .row_sum_o (rsum2)
  );

  c3f_cell #(.MAX_WIDTH(MAX_WIDTH), .HAS_STORE(1'b1)) u_cell_mid (
    .clk_i, .rst_ni,
    .ctrl_i    (ctrl),
    .rd_addr_i (cur_col),
    .wr_addr_i (c1_q),
    .kernel_i  (kmid_q),
    .pix_i     (pix_mid),
    .pix_up_o  (pix_top),
    .row_sum_o (rsum1)
  );

  c3f_cell #(.MAX_WIDTH(MAX_WIDTH), .HAS_STORE(1'b0)) u_cell_top (
    .clk_i, .rst_ni,
    .ctrl_i    (ctrl),
    .rd_addr_i (cur_col),
    .wr_addr_i (c1_q),
    .kernel_i  (ktop_q),
    .pix_i     (pix_top),
    .pix_up_o  (pix_unused),
    .row_sum_o (rsum0)
  );

  // ---------------- output ----------------
  assign m_axis_tvalid = vo_q;
  assign m_axis_tlast  = last_o_q;
  assign m_axis_tdata  = TDATA_O_W'({ccol_o_q, crow_o_q, sum_o_q});

`ifndef SYNTHESIS
  a_col_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q < CW'(MAX_WIDTH - 1) || col_q == CW'(MAX_WIDTH - 1))
    else $error("column count beyond line store depth");

  a_row_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_q < RW'(MAX_HEIGHT) || row_q == RW'(MAX_HEIGHT))
    else $error("row count past saturation");

  a_center_interior: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (crow_o_q != '0) && (ccol_o_q != '0))
    else $error("result centered on a border pixel");

  a_accept_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> v1_q)
    else $error("accepted pixel lost before stage 1");
`endif

endmodule

`default_nettype wire

// File: design/c3f_cell.sv
// One row cell of the 3x3 window: two window taps, three products, a row sum,
// and optionally the line store that feeds the row above. Uses c3f_pkg.
`default_nettype none

module c3f_cell #(
  parameter int MAX_WIDTH = c3f_pkg::DEF_MAX_WIDTH,
  parameter bit HAS_STORE = 1'b1
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  c3f_pkg::c3f_ctrl_t                   ctrl_i,
  input  wire  [$clog2(MAX_WIDTH)-1:0]         rd_addr_i,
  input  wire  [$clog2(MAX_WIDTH)-1:0]         wr_addr_i,
  input  wire  [c3f_pkg::KERNEL_W-1:0]         kernel_i,
  input  wire  [c3f_pkg::PIX_W-1:0]            pix_i,    // this row, stage 1
  output logic [c3f_pkg::PIX_W-1:0]            pix_up_o, // row above, stage 1
  output logic signed [c3f_pkg::ROW_W-1:0]     row_sum_o
);
  import c3f_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);

  logic [PIX_W-1:0]         win0_q, win1_q;  // columns c-2 and c-1
  logic signed [PROD_W-1:0] prod0_d, prod1_d, prod2_d;
  logic signed [PROD_W-1:0] prod0_q, prod1_q, prod2_q;
  logic signed [ROW_W-1:0]  row_sum_q;

  assign prod0_d = $signed({1'b0, win0_q}) * $signed(kernel_i[COEF_W-1:0]);
  assign prod1_d = $signed({1'b0, win1_q}) * $signed(kernel_i[2*COEF_W-1:COEF_W]);
  assign prod2_d = $signed({1'b0, pix_i})  * $signed(kernel_i[3*COEF_W-1:2*COEF_W]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win0_q <= '0;
      win1_q <= '0;
    end else if (ctrl_i.advance) begin
      win0_q <= win1_q;
      win1_q <= pix_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.advance) begin
      prod0_q <= prod0_d;
      prod1_q <= prod1_d;
      prod2_q <= prod2_d;
    end
    if (ctrl_i.sum_load) begin
      row_sum_q <= ROW_W'(prod0_q) + ROW_W'(prod1_q) + ROW_W'(prod2_q);
    end
  end

  assign row_sum_o = row_sum_q;

  if (HAS_STORE) begin : g_store
    logic [PIX_W-1:0] mem [MAX_WIDTH];
    logic [PIX_W-1:0] rd_q;
    logic [PIX_W-1:0] byp_pix_q;
    logic             byp_q;

    always_ff @(posedge clk_i) begin
      if (ctrl_i.advance) begin
        mem[wr_addr_i] <= pix_i;
      end
      if (ctrl_i.accept) begin
        rd_q <= mem[rd_addr_i];
      end
    end

    // read and write of the same column at one edge: take the written pixel
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        byp_q <= 1'b0;
      end else if (ctrl_i.accept) begin
        byp_q <= ctrl_i.advance && (rd_addr_i == wr_addr_i);
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctrl_i.accept) begin
        byp_pix_q <= pix_i;
      end
    end

    assign pix_up_o = byp_q ? byp_pix_q : rd_q;
  end else begin : g_no_store
    assign pix_up_o = '0;
  end

endmodule

`default_nettype wire

// File: dv/conv3x3_image_filter_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for conv3x3_image_filter_top: streams raster pixel frames,
// predicts every interior 3x3 result in order and checks the result stream.
// Depends on c3f_pkg and the filter RTL.

module conv3x3_image_filter_top_tb;
  import c3f_pkg::*;

  localparam int MAX_W = DEF_MAX_WIDTH;
  localparam int MAX_H = DEF_MAX_HEIGHT;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_PIXELS = 1050;

  typedef struct packed {
    logic [PIX_W-1:0] px;
    logic             frame_start;
  } pixel_item_t;

  typedef struct packed {
    logic [OUT_W-1:0] value;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             row_done;
  } filter_result_t;

  typedef enum logic [1:0] {SINK_FREE, SINK_RANDOM, SINK_SLOW} sink_mode_e;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  c3f_cfg_e             cfg_idx_i = CFG_KERNEL_TOP;
  logic [KERNEL_W-1:0]  cfg_wdata_i = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [PIX_W-1:0]     s_axis_tdata = '0;   // [7:0] pixel
  logic                 s_axis_tuser = 1'b0; // [0] frame_start
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  // [23:0] filtered_value, [32:24] center_row, [41:33] center_column, rest 0
  logic [TDATA_O_W-1:0] m_axis_tdata;
  logic                 m_axis_tlast;        // row_done

  conv3x3_image_filter_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Filter state as the predictor sees it
  logic [KERNEL_W-1:0] kern [3];
  logic [LWIDTH_W-1:0] width_reg;
  logic [PIX_W-1:0]    upper_mem [MAX_W];
  logic [PIX_W-1:0]    lower_mem [MAX_W];
  logic [PIX_W-1:0]    win [6];  // [row*2] = column c-2, [row*2+1] = column c-1
  int unsigned         col_cnt;
  int unsigned         row_cnt;

  pixel_item_t    pix_q [$];
  filter_result_t expected_q [$];

  int   pixels_in = 0;
  int   results_seen = 0;
  int   mismatches = 0;
  int   lost_results = 0;
  logic hold_armed = 1'b0;

  function automatic int eff_width(logic [LWIDTH_W-1:0] w);
    if (w < 3) return 3;
    if (w > MAX_W) return MAX_W;
    return int'(w);
  endfunction

  function automatic int coef_at(logic [KERNEL_W-1:0] k, int pos);
    return int'($signed(k[COEF_W*pos +: COEF_W]));
  endfunction

  // Advances the filter state by one pixel; returns 1 when a center completes
  function automatic bit convolve_pixel(input logic [PIX_W-1:0] px, input logic fs,
                                        output filter_result_t res);
    int unsigned      w;
    int unsigned      c;
    int unsigned      r;
    logic [PIX_W-1:0] col_new [3];
    int               sum;
    int               k;
    bit               hit;
    w = eff_width(width_reg);
    if (fs) begin
      col_cnt = 0;
      row_cnt = 0;
    end
    c = col_cnt;
    r = row_cnt;
    if (c >= MAX_W) c = MAX_W - 1;
    col_new[0] = upper_mem[c];
    col_new[1] = lower_mem[c];
    col_new[2] = px;
    res = '0;
    hit = 1'b0;
    if (r >= 2 && r < MAX_H && c >= 2) begin
      sum = 0;
      for (k = 0; k < 3; k++) begin
        sum += int'(win[2*k]) * coef_at(kern[k], 0);
        sum += int'(win[2*k+1]) * coef_at(kern[k], 1);
        sum += int'(col_new[k]) * coef_at(kern[k], 2);
      end
      res.value = sum[OUT_W-1:0];
      res.row = 9'(r - 1);
      res.col = 9'(c - 1);
      res.row_done = (c + 1 >= w);
      hit = 1'b1;
    end
    upper_mem[c] = col_new[1];
    lower_mem[c] = px;
    for (k = 0; k < 3; k++) begin
      win[2*k] = win[2*k+1];
      win[2*k+1] = col_new[k];
    end
    if (c + 1 >= w) begin
      col_cnt = 0;
      if (row_cnt < MAX_H) row_cnt++;
    end else begin
      col_cnt = c + 1;
    end
    return hit;
  endfunction

  function automatic logic [KERNEL_W-1:0] rand_kernel();
    logic [KERNEL_W-1:0] k;
    int                  p;
    k[31:0] = $urandom;
    k[35:32] = 4'($urandom_range(0, 15));
    case ($urandom_range(0, 2))
      0: ;  // fully random coefficients
      1: begin
        for (p = 0; p < 3; p++) k[COEF_W*p +: COEF_W] = 12'($urandom_range(0, 64) - 32);
      end
      default: begin
        for (p = 0; p < 3; p++) begin
          case ($urandom_range(0, 3))
            0: k[COEF_W*p +: COEF_W] = 12'h7FF;
            1: k[COEF_W*p +: COEF_W] = 12'h800;
            2: k[COEF_W*p +: COEF_W] = 12'h000;
            default: k[COEF_W*p +: COEF_W] = 12'hFFF;
          endcase
        end
      end
    endcase
    return k;
  endfunction

  function automatic logic [PIX_W-1:0] rand_pixel();
    if ($urandom_range(0, 7) == 0) return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic push_pixel(logic [PIX_W-1:0] px, logic fs);
    pix_q.push_back({px, fs});
  endtask

  task automatic write_reg(c3f_cfg_e idx, logic [KERNEL_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_LINE_WIDTH) width_reg = val[LWIDTH_W-1:0];
    else kern[int'(idx)] = val;
  endtask

  // All pixels taken, all results back, pipeline drained
  task automatic wait_idle();
    int n;
    while (pix_q.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    n = 0;
    while (expected_q.size() != 0 && n < 20000) begin
      @(posedge clk_i);
      n++;
    end
    if (expected_q.size() != 0) begin
      $error("%0d expected results never arrived", expected_q.size());
      lost_results += expected_q.size();
      expected_q.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic check_field(string name, int want, int got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Sender: bursts of random length separated by random gaps
  always @(posedge clk_i or negedge rst_ni) begin : pixel_driver
    pixel_item_t    item;
    filter_result_t res;
    logic           offer;
    int             gap_left;
    int             burst_left;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
      s_axis_tuser <= 1'b0;
      gap_left = 0;
      burst_left = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        pixels_in++;
        if (convolve_pixel(s_axis_tdata, s_axis_tuser, res)) expected_q.push_back(res);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        offer = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (pix_q.size() != 0) begin
          item = pix_q.pop_front();
          s_axis_tdata <= item.px;
          s_axis_tuser <= item.frame_start;
          offer = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
        s_axis_tvalid <= offer;
      end
    end
  end

  // Receiver: segments of free, random and slow acceptance, plus one long hold
  sink_mode_e sink_mode;
  int         sink_left;
  int         hold_left;
  logic       hold_done;

  always @(posedge clk_i or negedge rst_ni) begin : result_sink
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      sink_mode <= SINK_FREE;
      sink_left <= 0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (hold_armed && !hold_done) begin
      hold_left <= 300;
      hold_done <= 1'b1;
      m_axis_tready <= 1'b0;
    end else begin
      if (sink_left == 0) begin
        sink_left <= $urandom_range(8, 120);
        sink_mode <= sink_mode_e'($urandom_range(0, 2));
      end else begin
        sink_left <= sink_left - 1;
      end
      case (sink_mode)
        SINK_FREE:   m_axis_tready <= 1'b1;
        SINK_RANDOM: m_axis_tready <= ($urandom_range(0, 1) != 0);
        default:     m_axis_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk_i) begin : result_monitor
    filter_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        $error("unexpected result transaction, tdata=%h tlast=%b", m_axis_tdata, m_axis_tlast);
        mismatches++;
      end else begin
        want = expected_q.pop_front();
        check_field("filtered_value", int'($signed(want.value)),
                    int'($signed(m_axis_tdata[23:0])));
        check_field("center_row", int'(want.row), int'(m_axis_tdata[32:24]));
        check_field("center_column", int'(want.col), int'(m_axis_tdata[41:33]));
        check_field("row_done", int'(want.row_done), int'(m_axis_tlast));
        check_field("tdata_pad", 0, int'(m_axis_tdata[47:42]));
      end
    end
  end

  initial begin : stimulus
    int               i;
    int               k;
    int               n;
    int               w_eff;
    int               random_items;
    int               frames;
    int               shrinks;
    logic [LWIDTH_W-1:0] w_wr;
    kern[0] = KERNEL_EDGE_RST;
    kern[1] = KERNEL_MID_RST;
    kern[2] = KERNEL_EDGE_RST;
    width_reg = LWIDTH_RST;
    for (i = 0; i < MAX_W; i++) begin
      upper_mem[i] = '0;
      lower_mem[i] = '0;
    end
    for (i = 0; i < 6; i++) win[i] = '0;
    col_cnt = 0;
    row_cnt = 0;
    frames = 0;
    shrinks = 0;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset Laplacian on a 3x3 checkerboard
    write_reg(CFG_LINE_WIDTH, 36'd3);
    @(negedge clk_i);
    for (i = 0; i < 9; i++) push_pixel((i % 2 == 0) ? 8'hFF : 8'h00, i == 0);

    // Largest positive sum; width below 3 acts as 3
    wait_idle();
    for (k = 0; k < 3; k++) write_reg(c3f_cfg_e'(k), 36'h7FF7FF7FF);
    write_reg(CFG_LINE_WIDTH, 36'd2);
    @(negedge clk_i);
    for (i = 0; i < 9; i++) push_pixel(8'hFF, i == 0);

    // Most negative sum
    wait_idle();
    for (k = 0; k < 3; k++) write_reg(c3f_cfg_e'(k), 36'h800800800);
    write_reg(CFG_LINE_WIDTH, 36'd0);
    @(negedge clk_i);
    for (i = 0; i < 9; i++) push_pixel(8'hFF, i == 0);

    // Random frames, small widths, occasional stray frame_start
    random_items = 0;
    while (random_items < RANDOM_PIXELS) begin
      wait_idle();
      for (k = 0; k < 3; k++) if ($urandom_range(0, 1) != 0) write_reg(c3f_cfg_e'(k), rand_kernel());
      case ($urandom_range(0, 9))
        0: w_wr = 10'($urandom_range(0, 2));
        1: w_wr = 10'($urandom_range(13, 40));
        default: w_wr = 10'($urandom_range(3, 12));
      endcase
      write_reg(CFG_LINE_WIDTH, 36'(w_wr));
      w_eff = eff_width(w_wr);
      n = $urandom_range(3, 7) * w_eff + $urandom_range(0, w_eff - 1);
      @(negedge clk_i);
      for (i = 0; i < n; i++) push_pixel(rand_pixel(), i == 0 || $urandom_range(0, 99) == 0);
      random_items += n;
      frames++;
      // narrow the line mid-frame; the stopped column may already be past it
      if (w_eff > 3 && $urandom_range(0, 2) == 0) begin
        wait_idle();
        w_eff = $urandom_range(3, w_eff - 1);
        write_reg(CFG_LINE_WIDTH, 36'(w_eff));
        n = $urandom_range(2, 4) * w_eff;
        @(negedge clk_i);
        for (i = 0; i < n; i++) push_pixel(rand_pixel(), 1'b0);
        random_items += n;
        shrinks++;
      end
    end

    // Full-width frame through a width write above the maximum
    wait_idle();
    write_reg(CFG_KERNEL_MIDDLE, rand_kernel());
    write_reg(CFG_LINE_WIDTH, 36'd1023);
    @(negedge clk_i);
    for (i = 0; i < 3 * MAX_W + 5; i++) push_pixel(rand_pixel(), i == 0);

    // Narrow frame past the row limit, receiver held off early on
    wait_idle();
    write_reg(CFG_KERNEL_TOP, rand_kernel());
    write_reg(CFG_LINE_WIDTH, 36'd1);
    @(negedge clk_i);
    hold_armed = 1'b1;
    for (i = 0; i < 3 * (MAX_H + 3); i++) push_pixel(rand_pixel(), i == 0);

    wait_idle();
    $display("Ran %0d pixels, %0d results compared, %0d random frames (%0d narrowed mid-frame).",
             pixels_in, results_seen, frames, shrinks);
    $display("Kernels: reset Laplacian, extremes, random; widths 3..512 with out-of-range "
             , "writes; row limit reached.");
    if (mismatches == 0 && lost_results == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
